@@ hw/rtl/triangle_tangent_binormal_top_defines.svh @@
// Assertion helpers used by the checker file.
`ifndef TRIANGLE_TANGENT_BINORMAL_TOP_DEFINES_SVH
`define TRIANGLE_TANGENT_BINORMAL_TOP_DEFINES_SVH

// Same-cycle implication, sampled on clk, off while rst_n is low.
`define TTB_ASSERT_SAME(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, sampled on clk, off while rst_n is low.
`define TTB_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

@@ hw/rtl/ttb_pkg.sv @@
package ttb_pkg;

  localparam int COORD_WIDTH_DEF   = 32;
  localparam int OUT_FRAC_BITS_DEF = 14;
  // magnitudes are scaled below 2^NORM_BITS before the length is taken
  localparam int NORM_BITS         = 30;

  typedef enum logic [3:0] {
    S_IDLE,
    S_LOAD,
    S_MUL,
    S_CHK,
    S_VLOAD,
    S_SCALE,
    S_SQLOAD,
    S_SQ,
    S_ROOT,
    S_DIVLOAD,
    S_DIV,
    S_DONE
  } ttb_state_t;

  typedef struct packed {
    logic in_ready;
    logic mul_step;
  } ttb_ctrl_t;

endpackage

@@ hw/rtl/triangle_tangent_binormal_top.sv @@
// Per-triangle tangent and binormal generator.
// Input channel (in_*): one corner vertex per transfer, corners of a
// triangle list in order. in_tdata packs pos_x, pos_y, pos_z, tex_u, tex_v
// (COORD_WIDTH bits each, two's complement). The first two corners of a
// triangle are stored as they are taken; the third starts the computation.
// Result channel (out_*): one transfer per triangle with the unit tangent
// and unit binormal in signed Q1.OUT_FRAC_BITS, plus tuser flags.
// After the third corner, the seven cross terms are formed on a single
// bit-serial multiplier and the determinant is checked. Per vector the
// components are then scaled, squared and summed, the length is taken by
// a bit-pair square root and each component is divided by a restoring
// divider; the results then go to the output register. in_tready is low
// while a triangle is being worked on, so no new corner is taken then.
// Reset (synchronous, rst_n low) empties the corner buffer and drops any
// pending result. A stalled receiver keeps out_tvalid and the data steady;
// corners are still taken and a finished triangle waits in the last state
// until the output register is free.
module triangle_tangent_binormal_top
  import ttb_pkg::*;
#(
  parameter int COORD_WIDTH   = COORD_WIDTH_DEF,
  parameter int OUT_FRAC_BITS = OUT_FRAC_BITS_DEF
) (
  input  logic clk,
  input  logic rst_n,
  input  logic in_tvalid,
  output logic in_tready,
  // pos_x, pos_y, pos_z, tex_u, tex_v from bit 0 up
  input  logic [((5*COORD_WIDTH+7)/8)*8-1:0] in_tdata,
  output logic out_tvalid,
  input  logic out_tready,
  // tangent_x, tangent_y, tangent_z, binormal_x, binormal_y, binormal_z
  output logic [((6*(OUT_FRAC_BITS+2)+7)/8)*8-1:0] out_tdata,
  // degenerate_uv, zero_length
  output logic [1:0] out_tuser
);

  localparam int W      = COORD_WIDTH;
  localparam int OF     = OUT_FRAC_BITS;
  localparam int D      = W + 1;
  localparam int VW     = 2 * D + 1;
  localparam int NB     = NORM_BITS;
  localparam int MW     = (D > NB) ? D : NB;
  localparam int OW     = OF + 2;
  localparam int QB     = OF + 1;
  localparam int LW     = NB + 1;
  localparam int SUMW   = 2 * NB + 2;
  localparam int RTS    = SUMW / 2;
  localparam int RMW    = LW + 3;
  localparam int NW     = NB + OF + 2;
  localparam int DRW    = LW + 2;
  localparam int OUT_DW = ((6 * OW + 7) / 8) * 8;
  localparam int CW     = $clog2(MW + 1);

  function automatic logic [D-1:0] abs_d(input logic [D-1:0] x);
    abs_d = x[D-1] ? (~x + 1'b1) : x;
  endfunction

  function automatic logic [VW-1:0] abs_v(input logic [VW-1:0] x);
    abs_v = x[VW-1] ? (~x + 1'b1) : x;
  endfunction

  ttb_state_t state_r, state_nxt;
  ttb_ctrl_t  ctrl;

  logic [1:0]    corner_cnt_r;
  logic [W-1:0]  pos_r [2][3];
  logic [W-1:0]  tex_r [2][2];
  logic [W-1:0]  in_p  [3];
  logic [W-1:0]  in_t  [2];

  logic [D-1:0]  e1_r [3];
  logic [D-1:0]  e2_r [3];
  logic [D-1:0]  d1u_r, d1v_r, d2u_r, d2v_r;

  logic [2:0]    op_r;
  logic          ph_r;
  logic [CW-1:0] cnt_r;
  logic [1:0]    idx;
  logic [D-1:0]  opa, opb, op_a0, op_b0, op_a1, op_b1;

  logic [MW-1:0]   mcand_r;
  logic [2*MW-1:0] prod_r, prod_nxt;
  logic [MW:0]     msum;
  logic            mneg_r;
  logic [VW-1:0]   pmag, psign;
  logic            mul_done;

  logic [VW-1:0] t_r;
  logic [VW-1:0] vec_r [7];
  logic          flip_r, vsel_r;
  logic [1:0]    comp_r;
  logic [VW-1:0] c_r [3];
  logic          cneg_r [3];
  logic [VW-1:0] vsrc [3];
  logic [VW-1:0] call;
  logic          vzero;

  logic [SUMW-1:0] sum_r, rad_r, sum_add;
  logic [RMW-1:0]  rem_r, remsh, trial;
  logic [LW-1:0]   root_r;
  logic            root_ge;

  logic [NW-1:0]   nnum;
  logic [DRW-1:0]  drem_r, dt, dv;
  logic            dge;
  logic [QB-1:0]   nq_r, qv;
  logic [OW-1:0]   qo;

  logic [OW-1:0] res_t_r [3];
  logic [OW-1:0] res_b_r [3];
  logic          dg_r, zl_r;
  logic          out_valid_r;
  logic [OUT_DW-1:0] out_data_r;
  logic [1:0]    out_user_r;
  logic          out_load;

  assign in_p[0] = in_tdata[W-1:0];
  assign in_p[1] = in_tdata[2*W-1:W];
  assign in_p[2] = in_tdata[3*W-1:2*W];
  assign in_t[0] = in_tdata[4*W-1:3*W];
  assign in_t[1] = in_tdata[5*W-1:4*W];

  // operand pairs of the seven cross terms: det, tangent x/y/z, binormal x/y/z
  always_comb begin
    case (op_r)
      3'd1, 3'd4: idx = 2'd0;
      3'd2, 3'd5: idx = 2'd1;
      default:    idx = 2'd2;
    endcase
    case (op_r)
      3'd0: begin
        op_a0 = d1u_r; op_b0 = d2v_r; op_a1 = d1v_r; op_b1 = d2u_r;
      end
      3'd1, 3'd2, 3'd3: begin
        op_a0 = d2v_r; op_b0 = e1_r[idx]; op_a1 = d1v_r; op_b1 = e2_r[idx];
      end
      default: begin
        op_a0 = d1u_r; op_b0 = e2_r[idx]; op_a1 = d2u_r; op_b1 = e1_r[idx];
      end
    endcase
    opa = ph_r ? op_a1 : op_a0;
    opb = ph_r ? op_b1 : op_b0;
  end

  // shift-add multiplier, one multiplier bit per cycle
  assign msum     = {1'b0, prod_r[2*MW-1:MW]} + (prod_r[0] ? {1'b0, mcand_r} : '0);
  assign prod_nxt = {msum, prod_r[MW-1:1]};
  assign mul_done = (cnt_r == CW'(MW - 1));
  assign pmag     = VW'(prod_nxt[2*D-1:0]);
  assign psign    = mneg_r ? (~pmag + 1'b1) : pmag;
  assign sum_add  = sum_r + SUMW'(prod_nxt[2*NB-1:0]);

  always_comb begin
    for (int k = 0; k < 3; k++) begin
      vsrc[k] = vsel_r ? vec_r[4+k] : vec_r[1+k];
    end
    vzero = (vsrc[0] == '0) && (vsrc[1] == '0) && (vsrc[2] == '0);
  end
  assign call = c_r[0] | c_r[1] | c_r[2];

  // square root, two radicand bits per cycle
  assign remsh   = {rem_r[RMW-3:0], rad_r[SUMW-1:SUMW-2]};
  assign trial   = RMW'({root_r, 2'b01});
  assign root_ge = (remsh >= trial);

  // restoring divide of (c << (OF+1)) + len by 2*len
  assign nnum = (NW'(c_r[comp_r][NB-1:0]) << (OF + 1)) + NW'(root_r);
  assign dt   = {drem_r[LW:0], nq_r[QB-1]};
  assign dv   = DRW'({root_r, 1'b0});
  assign dge  = (dt >= dv);
  assign qv   = {nq_r[QB-2:0], dge};
  assign qo   = cneg_r[comp_r] ? (~OW'(qv) + 1'b1) : OW'(qv);

  assign out_load = (state_r == S_DONE) && (!out_valid_r || out_tready);

  // next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_IDLE:
        if (in_tvalid && corner_cnt_r == 2'd2) state_nxt = S_LOAD;
      S_LOAD:
        state_nxt = S_MUL;
      S_MUL:
        if (mul_done) state_nxt = (ph_r && op_r == 3'd6) ? S_CHK : S_LOAD;
      S_CHK:
        state_nxt = (vec_r[0] == '0) ? S_DONE : S_VLOAD;
      S_VLOAD:
        if (!vzero) state_nxt = S_SCALE;
        else if (vsel_r) state_nxt = S_DONE;
      S_SCALE:
        if (call[VW-1:NB] == '0) state_nxt = S_SQLOAD;
      S_SQLOAD:
        state_nxt = S_SQ;
      S_SQ:
        if (mul_done) state_nxt = (comp_r == 2'd2) ? S_ROOT : S_SQLOAD;
      S_ROOT:
        if (cnt_r == CW'(RTS - 1)) state_nxt = S_DIVLOAD;
      S_DIVLOAD:
        state_nxt = S_DIV;
      S_DIV:
        if (cnt_r == CW'(QB - 1)) begin
          if (comp_r != 2'd2) state_nxt = S_DIVLOAD;
          else state_nxt = vsel_r ? S_DONE : S_VLOAD;
        end
      S_DONE:
        if (!out_valid_r || out_tready) state_nxt = S_IDLE;
      default:
        state_nxt = S_IDLE;
    endcase
  end

  // control outputs
  always_comb begin
    ctrl = '0;
    case (state_r)
      S_IDLE:       ctrl.in_ready = 1'b1;
      S_MUL, S_SQ:  ctrl.mul_step = 1'b1;
      default:      ctrl = '0;
    endcase
  end

  assign in_tready = ctrl.in_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= S_IDLE;
      corner_cnt_r <= 2'd0;
      out_valid_r  <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (in_tvalid && ctrl.in_ready) begin
        corner_cnt_r <= (corner_cnt_r == 2'd2) ? 2'd0 : corner_cnt_r + 2'd1;
      end
      if (out_load) out_valid_r <= 1'b1;
      else if (out_tready) out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_tvalid && ctrl.in_ready) begin
      if (corner_cnt_r != 2'd2) begin
        for (int k = 0; k < 3; k++) pos_r[corner_cnt_r[0]][k] <= in_p[k];
        for (int k = 0; k < 2; k++) tex_r[corner_cnt_r[0]][k] <= in_t[k];
      end else begin
        for (int k = 0; k < 3; k++) begin
          e1_r[k] <= {pos_r[1][k][W-1], pos_r[1][k]} - {pos_r[0][k][W-1], pos_r[0][k]};
          e2_r[k] <= {in_p[k][W-1], in_p[k]} - {pos_r[0][k][W-1], pos_r[0][k]};
        end
        d1u_r <= {tex_r[1][0][W-1], tex_r[1][0]} - {tex_r[0][0][W-1], tex_r[0][0]};
        d1v_r <= {tex_r[1][1][W-1], tex_r[1][1]} - {tex_r[0][1][W-1], tex_r[0][1]};
        d2u_r <= {in_t[0][W-1], in_t[0]} - {tex_r[0][0][W-1], tex_r[0][0]};
        d2v_r <= {in_t[1][W-1], in_t[1]} - {tex_r[0][1][W-1], tex_r[0][1]};
        op_r  <= 3'd0;
        ph_r  <= 1'b0;
      end
    end

    // counter wraps to zero at the end of each multiply
    if (ctrl.mul_step) begin
      prod_r <= prod_nxt;
      cnt_r  <= mul_done ? '0 : cnt_r + CW'(1);
    end

    case (state_r)
      S_LOAD: begin
        mcand_r <= MW'(abs_d(opa));
        prod_r  <= {{MW{1'b0}}, MW'(abs_d(opb))};
        mneg_r  <= opa[D-1] ^ opb[D-1];
        cnt_r   <= '0;
      end
      S_MUL: begin
        if (mul_done) begin
          if (!ph_r) begin
            t_r  <= psign;
            ph_r <= 1'b1;
          end else begin
            vec_r[op_r] <= t_r - psign;
            ph_r <= 1'b0;
            op_r <= op_r + 3'd1;
          end
        end
      end
      S_CHK: begin
        for (int k = 0; k < 3; k++) begin
          res_t_r[k] <= '0;
          res_b_r[k] <= '0;
        end
        dg_r   <= (vec_r[0] == '0);
        zl_r   <= 1'b0;
        flip_r <= vec_r[0][VW-1];
        vsel_r <= 1'b0;
      end
      S_VLOAD: begin
        for (int k = 0; k < 3; k++) begin
          c_r[k]    <= abs_v(vsrc[k]);
          cneg_r[k] <= vsrc[k][VW-1] ^ flip_r;
        end
        if (vzero) begin
          zl_r   <= 1'b1;
          vsel_r <= 1'b1;
        end
        comp_r <= 2'd0;
        sum_r  <= '0;
      end
      S_SCALE: begin
        if (call[VW-1:NB] != '0) begin
          for (int k = 0; k < 3; k++) c_r[k] <= c_r[k] >> 1;
        end
      end
      S_SQLOAD: begin
        mcand_r <= MW'(c_r[comp_r][NB-1:0]);
        prod_r  <= {{MW{1'b0}}, MW'(c_r[comp_r][NB-1:0])};
        mneg_r  <= 1'b0;
        cnt_r   <= '0;
      end
      S_SQ: begin
        if (mul_done) begin
          sum_r <= sum_add;
          if (comp_r == 2'd2) begin
            rad_r  <= sum_add;
            rem_r  <= '0;
            root_r <= '0;
            comp_r <= 2'd0;
          end else begin
            comp_r <= comp_r + 2'd1;
          end
        end
      end
      S_ROOT: begin
        rem_r  <= root_ge ? (remsh - trial) : remsh;
        root_r <= {root_r[LW-2:0], root_ge};
        rad_r  <= rad_r << 2;
        cnt_r  <= cnt_r + 1'b1;
      end
      S_DIVLOAD: begin
        drem_r <= DRW'(nnum[NW-1:QB]);
        nq_r   <= nnum[QB-1:0];
        cnt_r  <= '0;
      end
      S_DIV: begin
        drem_r <= dge ? (dt - dv) : dt;
        nq_r   <= qv;
        cnt_r  <= cnt_r + 1'b1;
        if (cnt_r == CW'(QB - 1)) begin
          if (vsel_r) res_b_r[comp_r] <= qo;
          else res_t_r[comp_r] <= qo;
          if (comp_r == 2'd2) vsel_r <= 1'b1;
          else comp_r <= comp_r + 2'd1;
        end
      end
      default: begin
      end
    endcase

    if (out_load) begin
      out_data_r <= OUT_DW'({res_b_r[2], res_b_r[1], res_b_r[0],
                             res_t_r[2], res_t_r[1], res_t_r[0]});
      out_user_r <= {zl_r, dg_r};
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;
  assign out_tuser  = out_user_r;

endmodule

@@ hw/rtl/ttb_checker.sv @@
`include "triangle_tangent_binormal_top_defines.svh"

module ttb_checker #(
  parameter int DW = 96
) (
  input logic          clk,
  input logic          rst_n,
  input logic          out_tvalid,
  input logic          out_tready,
  input logic [DW-1:0] out_tdata,
  input logic [1:0]    out_tuser
);

  `TTB_ASSERT_NEXT(a_out_valid_hold, out_tvalid && !out_tready, out_tvalid, "result dropped while stalled")
  `TTB_ASSERT_NEXT(a_out_data_hold, out_tvalid && !out_tready, $stable(out_tdata) && $stable(out_tuser), "result changed while stalled")
  `TTB_ASSERT_SAME(a_degen_zero, out_tvalid && out_tuser[0], out_tdata == '0, "degenerate triangle with nonzero vectors")
  `TTB_ASSERT_SAME(a_degen_flags, out_tvalid && out_tuser[0], !out_tuser[1], "degenerate triangle also flagged zero length")

endmodule

bind triangle_tangent_binormal_top ttb_checker #(
  .DW(OUT_DW)
) u_ttb_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .out_tvalid(out_tvalid),
  .out_tready(out_tready),
  .out_tdata (out_tdata),
  .out_tuser (out_tuser)
);

@@ verif/tb_triangle_tangent_binormal_top.sv @@
module tb_triangle_tangent_binormal_top;
  import ttb_pkg::*;

  localparam int CW = 32;
  localparam int OFB = 14;
  localparam int OW = OFB + 2;

  typedef struct {
    logic signed [CW-1:0] px, py, pz, tu, tv;
    bit hold;  // wait for all outstanding triangles before sending
  } corner_t;

  typedef struct {
    logic [OW-1:0] comp[6];
    logic degenerate_uv;
    logic zero_length;
  } basis_t;

  logic clk = 0;
  logic rst_n = 0;
  logic in_tvalid = 0;
  logic in_tready;
  logic [159:0] in_tdata = '0;
  logic out_tvalid;
  logic out_tready = 0;
  logic [95:0] out_tdata;
  logic [1:0] out_tuser;

  corner_t corner_q[$];
  basis_t basis_q[$];
  corner_t cur;
  int gap_cnt = 0;
  int stall_cnt = 0;
  bit failed = 0;

  // corners 0 and 1 of the triangle being collected
  logic signed [CW-1:0] held_pos[6];
  logic signed [CW-1:0] held_uv[4];
  int held_cnt = 0;

  triangle_tangent_binormal_top uut (
    .clk(clk), .rst_n(rst_n),
    .in_tvalid(in_tvalid), .in_tready(in_tready), .in_tdata(in_tdata),
    .out_tvalid(out_tvalid), .out_tready(out_tready),
    .out_tdata(out_tdata), .out_tuser(out_tuser)
  );

  initial begin
    forever #4 clk = ~clk;
  end

  function automatic int idle_len();
    int r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(10, 60);
  endfunction

  function automatic longint unsigned floor_sqrt(longint unsigned x);
    longint unsigned res, b;
    res = 0;
    b = 64'd1 << 62;
    while (b > x) b >>= 2;
    while (b != 0) begin
      if (x >= res + b) begin
        x -= res + b;
        res = (res >> 1) + b;
      end else begin
        res >>= 1;
      end
      b >>= 2;
    end
    return res;
  endfunction

  function automatic bit unit_vec(input logic signed [127:0] v0, v1, v2, input bit flip,
                                  output logic [OW-1:0] o0, o1, o2);
    logic [127:0] mag[3];
    logic [127:0] all;
    bit neg[3];
    longint unsigned c[3], sum, len, q;
    logic [OW-1:0] res[3];
    int n, sh;
    neg[0] = v0 < 0; neg[1] = v1 < 0; neg[2] = v2 < 0;
    mag[0] = neg[0] ? -v0 : v0;
    mag[1] = neg[1] ? -v1 : v1;
    mag[2] = neg[2] ? -v2 : v2;
    all = mag[0] | mag[1] | mag[2];
    o0 = '0; o1 = '0; o2 = '0;
    if (all == 0) return 0;
    n = 0;
    for (int i = 0; i < 128; i++) if (all[i]) n = i + 1;
    sh = n > NORM_BITS ? n - NORM_BITS : 0;
    sum = 0;
    for (int i = 0; i < 3; i++) begin
      c[i] = 64'(mag[i] >> sh);
      sum += c[i] * c[i];
    end
    len = floor_sqrt(sum);
    for (int i = 0; i < 3; i++) begin
      q = ((c[i] << (OFB + 1)) + len) / (2 * len);
      res[i] = (neg[i] ^ flip) ? OW'(-q) : OW'(q);
    end
    o0 = res[0]; o1 = res[1]; o2 = res[2];
    return 1;
  endfunction

  // Tracks the corner buffer and queues the basis when a triangle completes.
  function automatic void track_corner(corner_t v);
    logic signed [127:0] e1[3], e2[3], tng[3], bnm[3];
    logic signed [127:0] d1u, d1v, d2u, d2v, det, p[3];
    basis_t b;
    bit ok_t, ok_b;
    p[0] = v.px; p[1] = v.py; p[2] = v.pz;
    if (held_cnt < 2) begin
      for (int i = 0; i < 3; i++) held_pos[held_cnt*3 + i] = p[i][CW-1:0];
      held_uv[held_cnt*2] = v.tu;
      held_uv[held_cnt*2 + 1] = v.tv;
      held_cnt++;
      return;
    end
    held_cnt = 0;
    for (int i = 0; i < 3; i++) begin
      e1[i] = 128'(held_pos[3+i]) - 128'(held_pos[i]);
      e2[i] = p[i] - 128'(held_pos[i]);
    end
    d1u = 128'(held_uv[2]) - 128'(held_uv[0]);
    d1v = 128'(held_uv[3]) - 128'(held_uv[1]);
    d2u = 128'(v.tu) - 128'(held_uv[0]);
    d2v = 128'(v.tv) - 128'(held_uv[1]);
    for (int i = 0; i < 6; i++) b.comp[i] = '0;
    b.degenerate_uv = 0;
    b.zero_length = 0;
    det = d1u * d2v - d1v * d2u;
    if (det == 0) begin
      b.degenerate_uv = 1;
    end else begin
      for (int i = 0; i < 3; i++) begin
        tng[i] = d2v * e1[i] - d1v * e2[i];
        bnm[i] = d1u * e2[i] - d2u * e1[i];
      end
      ok_t = unit_vec(tng[0], tng[1], tng[2], det < 0, b.comp[0], b.comp[1], b.comp[2]);
      ok_b = unit_vec(bnm[0], bnm[1], bnm[2], det < 0, b.comp[3], b.comp[4], b.comp[5]);
      b.zero_length = !(ok_t && ok_b);
    end
    basis_q = {basis_q, b};
  endfunction

  // input driver
  always @(posedge clk) begin
    bit nxt_valid;
    int nxt_gap;
    nxt_valid = in_tvalid;
    nxt_gap = gap_cnt;
    if (rst_n) begin
      if (in_tvalid && in_tready) begin
        track_corner(cur);
        nxt_valid = 0;
        nxt_gap = idle_len();
      end
      if (!nxt_valid) begin
        if (nxt_gap > 0) begin
          nxt_gap--;
        end else if (corner_q.size() != 0 && !(corner_q[0].hold && basis_q.size() != 0)) begin
          cur = corner_q.pop_front();
          in_tdata <= {cur.tv, cur.tu, cur.pz, cur.py, cur.px};
          nxt_valid = 1;
        end
      end
    end
    in_tvalid <= nxt_valid;
    gap_cnt <= nxt_gap;
  end

  // result monitor and receiver stalls
  always @(posedge clk) begin
    basis_t exp_b;
    if (rst_n) begin
      if (out_tvalid && out_tready) begin
        if (basis_q.size() == 0) begin
          $display("%0t: unexpected result tdata=%h tuser=%b", $time, out_tdata, out_tuser);
          failed = 1;
        end else begin
          exp_b = basis_q.pop_front();
          for (int i = 0; i < 6; i++)
            if (out_tdata[i*OW +: OW] !== exp_b.comp[i]) begin
              $display("%0t: component %0d expected %h actual %h", $time, i,
                       exp_b.comp[i], out_tdata[i*OW +: OW]);
              failed = 1;
            end
          if (out_tuser[0] !== exp_b.degenerate_uv) begin
            $display("%0t: degenerate_uv expected %b actual %b", $time,
                     exp_b.degenerate_uv, out_tuser[0]);
            failed = 1;
          end
          if (out_tuser[1] !== exp_b.zero_length) begin
            $display("%0t: zero_length expected %b actual %b", $time,
                     exp_b.zero_length, out_tuser[1]);
            failed = 1;
          end
        end
      end
      if (stall_cnt > 0) begin
        stall_cnt <= stall_cnt - 1;
        out_tready <= 0;
      end else if ($urandom_range(0, 3) == 0) begin
        stall_cnt <= idle_len();
        out_tready <= 0;
      end else begin
        out_tready <= 1;
      end
    end
  end

  function automatic void add_corner(int px, int py, int pz, int tu, int tv, bit hold = 0);
    corner_t c;
    c.px = px; c.py = py; c.pz = pz; c.tu = tu; c.tv = tv; c.hold = hold;
    corner_q = {corner_q, c};
  endfunction

  function automatic int rnd_coord(int kind);
    if (kind == 0) return $urandom;
    if (kind == 1) return int'($urandom_range(0, 8)) - 4;
    return int'($urandom_range(0, 1 << 20)) - (1 << 19);
  endfunction

  initial begin
    int kind, tu0, tv0, xmax, xmin;
    xmax = 32'h7fffffff;
    xmin = 32'h80000000;
    // all zero: degenerate UV
    add_corner(0, 0, 0, 0, 0); add_corner(0, 0, 0, 0, 0); add_corner(0, 0, 0, 0, 0);
    // plain right triangle
    add_corner(0, 0, 0, 0, 0);
    add_corner(65536, 0, 0, 65536, 0);
    add_corner(0, 65536, 0, 0, 65536);
    // negative determinant (mirrored UV)
    add_corner(0, 0, 0, 0, 0);
    add_corner(65536, 0, 0, 0, 65536);
    add_corner(0, 65536, 0, 65536, 0);
    // collapsed positions: both vectors zero
    add_corner(5, 5, 5, 0, 0); add_corner(5, 5, 5, 1, 0); add_corner(5, 5, 5, 0, 1);
    // e1 zero only: tangent zero, binormal live
    add_corner(0, 0, 0, 0, 0); add_corner(0, 0, 0, 1, 0); add_corner(3, -7, 2, 0, 1);
    // field extremes
    add_corner(xmin, xmax, xmin, xmin, xmin);
    add_corner(xmax, xmin, xmax, xmax, xmin);
    add_corner(xmin, xmin, xmax, xmin, xmax);
    add_corner(xmax, xmax, xmax, xmax, xmax);
    add_corner(xmin, xmin, xmin, xmin, xmin);
    add_corner(-1, 0, 1, xmax, xmin, 1);
    for (int t = 0; t < 244; t++) begin
      kind = $urandom_range(0, 2);
      if ($urandom_range(0, 9) == 0) begin
        // repeated UV: degenerate
        tu0 = rnd_coord(kind);
        tv0 = rnd_coord(kind);
        for (int k = 0; k < 3; k++)
          add_corner(rnd_coord(kind), rnd_coord(kind), rnd_coord(kind), tu0, tv0,
                     k == 0 && t == 120);
      end else begin
        for (int k = 0; k < 3; k++)
          add_corner(rnd_coord(kind), rnd_coord(kind), rnd_coord(kind),
                     rnd_coord(kind), rnd_coord(kind), k == 0 && t == 120);
      end
    end
    repeat (10) @(posedge clk);
    rst_n <= 1;
    wait (corner_q.size() == 0 && !in_tvalid && basis_q.size() == 0);
    repeat (1500) @(posedge clk);
    if (!failed && basis_q.size() == 0)
      $display("** triangle_tangent_binormal_top: PASSED **");
    else
      $display("** triangle_tangent_binormal_top: FAILED **");
    $finish;
  end

  initial begin
    #40000000;
    $display("** triangle_tangent_binormal_top: FAILED **");
    $finish;
  end

endmodule

@@ sim.f @@
+incdir+hw/rtl
hw/rtl/ttb_pkg.sv
hw/rtl/triangle_tangent_binormal_top.sv
hw/rtl/ttb_checker.sv
verif/tb_triangle_tangent_binormal_top.sv
